// ===== hdl/brs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// shared types and constants of the byte stream reassembler
// ----------------------------------------------------------------------------
package brs_pkg;

	// window geometry
	localparam int WINDOW  = 4096;
	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int IDX_W   = 64;
	localparam int TAG_W   = IDX_W - SLOT_W;
	localparam int ROOM_W  = 13;
	localparam int COUNT_W = 13;

	localparam logic [ROOM_W-1:0] ROOM_MAX = ROOM_W'(WINDOW);

	// action codes
	localparam logic [1:0] ACT_DATA  = 2'd0;
	localparam logic [1:0] ACT_FINAL = 2'd1;
	localparam logic [1:0] ACT_MARK  = 2'd2;
	localparam logic [1:0] ACT_DRAIN = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [IDX_W-1:0]  stream_index;
		logic [7:0]        byte_value;
		logic [ROOM_W-1:0] room;
	} brs_in_t;

	typedef struct packed {
		logic               byte_valid;
		logic [7:0]         out_byte;
		logic               stream_closed;
		logic [COUNT_W-1:0] bytes_waiting;
	} brs_out_t;

	// one window slot: occupied flag, upper index bits, payload byte
	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [7:0]       data;
	} brs_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr_a;
		logic [SLOT_W-1:0] addr_b;
	} brs_rd_req_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		brs_entry_t        entry;
	} brs_wr_req_t;

endpackage
`default_nettype wire

// ===== hdl/brs_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_window
// window buffer: two read ports, one write port, clearing pass after reset
// and forwarding of the last write into the read data
// ----------------------------------------------------------------------------
module brs_window (
	input  wire                  clk,
	input  wire                  arst_n,
	input  brs_pkg::brs_rd_req_t rd,
	input  brs_pkg::brs_wr_req_t wr,
	output brs_pkg::brs_entry_t  ent_a,
	output brs_pkg::brs_entry_t  ent_b,
	output logic                 busy
);
	import brs_pkg::*;

	brs_entry_t mem [WINDOW];

	brs_entry_t        rda_q;
	brs_entry_t        rdb_q;
	logic [SLOT_W-1:0] raddr_a_q;
	logic [SLOT_W-1:0] raddr_b_q;

	logic              fwd_valid_q;
	logic [SLOT_W-1:0] fwd_addr_q;
	brs_entry_t        fwd_ent_q;

	logic [SLOT_W:0]   clr_q;

	logic              we;
	logic [SLOT_W-1:0] wa;
	brs_entry_t        wd;

	assign busy = ~clr_q[SLOT_W];

	always_comb begin
		if (busy) begin
			we = 1'b1;
			wa = clr_q[SLOT_W-1:0];
			wd = '0;
		end else begin
			we = wr.en;
			wa = wr.addr;
			wd = wr.entry;
		end
	end

	// clearing sweep, one slot a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd.en) begin
			rda_q <= mem[rd.addr_a];
			rdb_q <= mem[rd.addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			raddr_a_q <= rd.addr_a;
			raddr_b_q <= rd.addr_b;
		end
		if (wr.en && !busy) begin
			fwd_addr_q <= wr.addr;
			fwd_ent_q  <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr.en && !busy) begin
			fwd_valid_q <= 1'b1;
		end
	end

	// a write landing in the cycle of the read is seen through the bypass
	assign ent_a = (fwd_valid_q && fwd_addr_q == raddr_a_q) ? fwd_ent_q : rda_q;
	assign ent_b = (fwd_valid_q && fwd_addr_q == raddr_b_q) ? fwd_ent_q : rdb_q;

	a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !rd.en) else $error("read issued during clearing pass");

	a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr.en) else $error("write issued during clearing pass");

	a_clear_runs_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy) else $error("clearing pass restarted");

endmodule
`default_nettype wire

// ===== hdl/byte_stream_reassembler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_reassembler
// puts out-of-order stream bytes back in order through a window buffer and
// releases at most one in-order byte per request
// ----------------------------------------------------------------------------
//  channel  | ports                              | carries
//  ---------+------------------------------------+-----------------------------
//  item     | item_valid, item_ready, item       | action, index, byte, room
//  result   | result_valid, result_ready, result | released byte, closed, count
//
//  one request per cycle sustained while results are taken; once its request
//  is accepted, each result is made by a window read, then an update into
//  the output register; the window is a 4096 x 61 memory; both slot reads
//  of a request are issued at acceptance and its write, if any, lands when
//  the update stage fires; after reset a clearing pass sweeps the window,
//  item_ready stays low for its length
//  a stalled result holds the update stage, and item_ready then stays low
// ----------------------------------------------------------------------------
module byte_stream_reassembler (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_ready,
	input  brs_pkg::brs_in_t  item,
	output logic              result_valid,
	input  wire               result_ready,
	output brs_pkg::brs_out_t result
);
	import brs_pkg::*;

	// stream state
	logic [IDX_W-1:0]   nn_q;          // next needed index
	logic               end_known_q;
	logic [IDX_W-1:0]   end_pos_q;
	logic [COUNT_W-1:0] count_q;       // bytes stored, not yet released
	logic               closed_q;

	// update stage
	logic               valid_s1;
	brs_in_t            item_s1;

	// output register
	logic               result_valid_q;
	brs_out_t           result_q;

	// window
	brs_rd_req_t        rd_req;
	brs_wr_req_t        wr_req;
	brs_entry_t         ent_a;
	brs_entry_t         ent_b;
	logic               win_busy;

	// update stage logic
	logic               out_free;
	logic               fire_s1;
	logic               accept;
	logic [ROOM_W-1:0]  room_c;
	logic               end_set;
	logic               end_known_n;
	logic [IDX_W-1:0]   end_pos_n;
	logic [IDX_W-1:0]   idx_gap;
	logic               in_window;
	logic               past_end;
	logic               is_data;
	logic               keep;
	logic               hit_a;
	logic               store;
	logic               head_now;
	logic               hit_b;
	logic               release_b;
	logic [7:0]         rel_byte;
	logic [IDX_W-1:0]   nn_inc;
	logic [IDX_W-1:0]   nn_n;
	logic               closed_n;
	logic [COUNT_W-1:0] count_n;
	logic [SLOT_W-1:0]  head_next;

	brs_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd_req),
		.wr     (wr_req),
		.ent_a  (ent_a),
		.ent_b  (ent_b),
		.busy   (win_busy)
	);

	// handshake: the update stage moves whenever the output register can take
	assign out_free   = !result_valid_q || result_ready;
	assign fire_s1    = valid_s1 && out_free;
	assign item_ready = !win_busy && (!valid_s1 || out_free);
	assign accept     = item_valid && item_ready;

	// room above the window size counts as the window size
	assign room_c = (item_s1.room > ROOM_MAX) ? ROOM_MAX : item_s1.room;

	// end mark is taken only once
	always_comb begin
		end_set     = !end_known_q &&
			(item_s1.action == ACT_FINAL || item_s1.action == ACT_MARK);
		end_known_n = end_known_q || end_set;
		if (end_set) begin
			end_pos_n = (item_s1.action == ACT_FINAL) ?
				item_s1.stream_index + 64'd1 : item_s1.stream_index;
		end else begin
			end_pos_n = end_pos_q;
		end
	end

	// store decision
	assign idx_gap   = item_s1.stream_index - nn_q;
	assign in_window = (item_s1.stream_index >= nn_q) && (idx_gap < IDX_W'(room_c));
	assign past_end  = end_known_n && (item_s1.stream_index >= end_pos_n);
	assign is_data   = (item_s1.action == ACT_DATA) || (item_s1.action == ACT_FINAL);
	assign keep      = !closed_q && is_data && in_window && !past_end;

	// a slot holds the index it was written with; a tag match means present
	assign hit_a = ent_a.valid && (ent_a.tag == item_s1.stream_index[IDX_W-1:SLOT_W]);
	assign store = keep && !hit_a;

	// head release, including a byte that lands on the head itself
	assign head_now  = store && (item_s1.stream_index == nn_q);
	assign hit_b     = ent_b.valid && (ent_b.tag == nn_q[IDX_W-1:SLOT_W]);
	assign release_b = !closed_q && (room_c != '0) && (head_now || hit_b);
	assign rel_byte  = head_now ? item_s1.byte_value : ent_b.data;

	assign nn_inc  = nn_q + 64'd1;
	assign nn_n    = release_b ? nn_inc : nn_q;
	assign closed_n = closed_q || (end_known_n &&
		(release_b ? (nn_inc == end_pos_n) : (nn_q == end_pos_n)));
	assign count_n = count_q + COUNT_W'(store) - COUNT_W'(release_b);

	// head slot for the request entering now
	assign head_next = (fire_s1 && release_b) ? nn_inc[SLOT_W-1:0] : nn_q[SLOT_W-1:0];

	always_comb begin
		rd_req.en     = accept;
		rd_req.addr_a = item.stream_index[SLOT_W-1:0];
		rd_req.addr_b = head_next;

		// released slots need no write: their tag no longer matches the head
		wr_req.en          = fire_s1 && store;
		wr_req.addr        = item_s1.stream_index[SLOT_W-1:0];
		wr_req.entry.valid = 1'b1;
		wr_req.entry.tag   = item_s1.stream_index[IDX_W-1:SLOT_W];
		wr_req.entry.data  = item_s1.byte_value;
	end

	// update stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nn_q        <= '0;
			end_known_q <= 1'b0;
			end_pos_q   <= '0;
			count_q     <= '0;
			closed_q    <= 1'b0;
		end else if (fire_s1) begin
			nn_q        <= nn_n;
			end_known_q <= end_known_n;
			end_pos_q   <= end_pos_n;
			count_q     <= count_n;
			closed_q    <= closed_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_q.byte_valid    <= release_b;
			result_q.out_byte      <= release_b ? rel_byte : 8'd0;
			result_q.stream_closed <= closed_n;
			result_q.bytes_waiting <= count_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q) else $error("closed flag dropped");

	a_head_steps_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> (nn_q == $past(nn_q) || nn_q == $past(nn_q) + 64'd1))
		else $error("head moved by more than one");

	a_head_still_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(nn_q)) else $error("head moved without a request");

	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(WINDOW)) else $error("waiting count beyond window");

	a_no_release_when_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && closed_q) |-> !release_b && !store)
		else $error("window touched after close");

endmodule
`default_nettype wire

// ===== test/byte_stream_reassembler_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_reassembler_test
// self-checking bench: a queue-fed driver sends byte requests, a shadow of the
// reassembly window predicts every result, and a monitor compares each
// result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module byte_stream_reassembler_test;
	import brs_pkg::*;

	localparam int BODY_REQUESTS = 1600;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int TAIL_CYCLES   = 8;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_ready;
	brs_in_t  item         = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	brs_out_t result;

	// shadow of the reassembly window
	bit   [7:0]         win_data [WINDOW];
	bit                 win_held [WINDOW];
	logic [IDX_W-1:0]   next_pos    = '0;
	logic               end_seen    = 1'b0;
	logic [IDX_W-1:0]   end_pos     = '0;
	logic [COUNT_W-1:0] held_count  = '0;
	logic               stream_done = 1'b0;

	brs_in_t  byte_requests [$];
	brs_out_t expected_results [$];
	brs_out_t want;

	int send_idle_pct = 30;
	int recv_idle_pct = 72;
	int requests_made = 0;
	int mismatches    = 0;
	int cycle_count   = 0;

	byte_stream_reassembler u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// one request through the shadow window: end mark, store, release, close
	function automatic brs_out_t reassemble(input brs_in_t req);
		int unsigned       eff_room;
		logic [SLOT_W-1:0] slot;
		logic              take;
		brs_out_t          res;
		res = '0;
		// room beyond the window is worth no more than the window
		eff_room = (req.room > ROOM_MAX) ? WINDOW : req.room;
		// only the first end mark counts, a final byte at the top index wraps to 0
		if (!end_seen && (req.action == ACT_FINAL || req.action == ACT_MARK)) begin
			end_seen = 1'b1;
			end_pos  = (req.action == ACT_FINAL) ? req.stream_index + 64'd1 : req.stream_index;
		end
		if (!stream_done && (req.action == ACT_DATA || req.action == ACT_FINAL)) begin
			take = req.stream_index >= next_pos &&
				(req.stream_index - next_pos) < IDX_W'(eff_room);
			// nothing at or beyond a known end is kept
			if (end_seen && req.stream_index >= end_pos)
				take = 1'b0;
			slot = req.stream_index[SLOT_W-1:0];
			// a duplicate leaves the first copy in place
			if (take && !win_held[slot]) begin
				win_held[slot] = 1'b1;
				win_data[slot] = req.byte_value;
				held_count     = held_count + 1'b1;
			end
		end
		// at most one in-order byte leaves per request, and only with room
		if (!stream_done && eff_room != 0) begin
			slot = next_pos[SLOT_W-1:0];
			if (win_held[slot]) begin
				res.byte_valid = 1'b1;
				res.out_byte   = win_data[slot];
				win_held[slot] = 1'b0;
				next_pos       = next_pos + 1'b1;
				if (held_count != 0)
					held_count = held_count - 1'b1;
			end
		end
		if (end_seen && next_pos == end_pos)
			stream_done = 1'b1;
		res.stream_closed = stream_done;
		res.bytes_waiting = held_count;
		return res;
	endfunction

	task automatic push_request(input logic [1:0] act, input logic [IDX_W-1:0] idx,
		input int val, input int rm);
		brs_in_t req;
		req.action       = act;
		req.stream_index = idx;
		req.byte_value   = 8'(val);
		req.room         = ROOM_W'(rm);
		byte_requests.push_back(req);
		requests_made++;
	endtask

	task automatic compare_field(input string field, input logic [COUNT_W-1:0] exp_val,
		input logic [COUNT_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, field, exp_val, got_val);
			mismatches = mismatches + 1;
		end
	endtask

	// driver: predicts on acceptance, then presents the next request or a gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && item_ready)
				expected_results.push_back(reassemble(item));
			if (!item_valid || item_ready) begin
				if (byte_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item       <= byte_requests.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: every accepted result is checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result expected none, got %p", $time, result);
					mismatches = mismatches + 1;
				end else begin
					want = expected_results.pop_front();
					compare_field("byte_valid", want.byte_valid, result.byte_valid);
					compare_field("out_byte", want.out_byte, result.out_byte);
					compare_field("stream_closed", want.stream_closed, result.stream_closed);
					compare_field("bytes_waiting", want.bytes_waiting, result.bytes_waiting);
				end
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog, generous against the clearing pass and the slowest stalls
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [IDX_W-1:0] base;
		int               k;
		int               pick;
		int               o;
		int               t;
		int               n;
		int               rm;
		int               order [64];
		bit               wrap_end;

		// ---- directed opening, window empty and head at 0
		// drain on an empty window releases nothing
		push_request(ACT_DRAIN, 0, 8'h00, WINDOW);
		// zero room refuses even the head byte
		push_request(ACT_DATA, 0, 8'h00, 0);
		// saturated room, byte parked one ahead of the head
		push_request(ACT_DATA, 1, 8'hFF, 8191);
		// duplicate must not overwrite the parked value
		push_request(ACT_DATA, 1, 8'h00, WINDOW);
		// first index past the window, then the last one inside
		push_request(ACT_DATA, WINDOW, 8'hA5, WINDOW);
		push_request(ACT_DATA, WINDOW - 1, 8'h5A, WINDOW);
		// room edge: refused at distance == room, kept with one more room
		push_request(ACT_DATA, 2, 8'h81, 2);
		push_request(ACT_DATA, 2, 8'h81, 3);
		// top of the index space lies far outside the window
		push_request(ACT_DATA, '1, 8'hFF, WINDOW);
		// head byte with the smallest room: stored and released by one request
		push_request(ACT_DATA, 0, 8'h00, 1);
		// zero room holds back a release that is ready
		push_request(ACT_DRAIN, '1, 8'hFF, 0);
		push_request(ACT_DRAIN, 0, 8'h00, 1);
		// byte already delivered is stale
		push_request(ACT_DATA, 0, 8'h33, WINDOW);
		push_request(ACT_DATA, 3, 8'hC3, 8191);
		push_request(ACT_DRAIN, 0, 8'h00, 8191);

		// ---- random body, refilled from the live head position
		while (requests_made < BODY_REQUESTS) begin
			@(negedge clk);
			if (requests_made >= 2 * BODY_REQUESTS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (requests_made >= BODY_REQUESTS / 3) begin
				send_idle_pct = 72;
				recv_idle_pct = 30;
			end
			if (byte_requests.size() < 4) begin
				base = next_pos;
				pick = $urandom_range(99);
				if (pick < 78) begin
					// a run of bytes from the head, shuffled, with the odd drain
					k = $urandom_range(40, 1);
					for (n = 0; n < k; n++)
						order[n] = n;
					for (n = k - 1; n > 0; n--) begin
						t        = $urandom_range(n, 0);
						o        = order[n];
						order[n] = order[t];
						order[t] = o;
					end
					for (n = 0; n < k; n++) begin
						o    = order[n];
						pick = $urandom_range(99);
						// mostly enough room, sometimes short, sometimes saturated
						if (pick < 6)
							rm = $urandom_range(o, 0);
						else if (pick < 20)
							rm = $urandom_range(8191, WINDOW + 1);
						else
							rm = $urandom_range(WINDOW, o + 1);
						push_request(ACT_DATA, base + o, $urandom_range(255), rm);
						if ($urandom_range(9) == 0)
							push_request(ACT_DRAIN, {$urandom, $urandom},
								$urandom_range(255), $urandom_range(8191));
					end
				end else if (pick < 90) begin
					// far ahead of the head, slot may wrap, room right at the edge or the full window
					o    = $urandom_range(WINDOW - 1, 41);
					pick = $urandom_range(2);
					push_request(ACT_DATA, base + o, $urandom_range(255),
						(pick == 0) ? WINDOW : o + pick - 1);
				end else if (base >= 50 && $urandom_range(1) == 1) begin
					// stale retransmission
					push_request(ACT_DATA, base - $urandom_range(50, 1), $urandom_range(255),
						$urandom_range(8191));
				end else begin
					// noise across the whole index space
					push_request($urandom_range(1) ? ACT_DRAIN : ACT_DATA, {$urandom, $urandom},
						$urandom_range(255), $urandom_range(8191));
				end
			end
		end

		// ---- end of stream, head position known exactly once all is accepted
		while (byte_requests.size() != 0 || item_valid)
			@(negedge clk);
		base     = next_pos;
		wrap_end = $urandom_range(1);
		if (wrap_end) begin
			// final byte at the top index: end wraps to 0 and the stream never closes
			push_request(ACT_FINAL, '1, $urandom_range(255), WINDOW);
			push_request(ACT_DATA, base, $urandom_range(255), WINDOW);
			push_request(ACT_DATA, base + 1, $urandom_range(255), WINDOW);
			for (n = 0; n < 30; n++)
				push_request(ACT_DRAIN, 0, 0, $urandom_range(8191, 1));
			push_request(ACT_MARK, base, 0, WINDOW);
			push_request(ACT_FINAL, base + 2, $urandom_range(255), WINDOW);
		end else begin
			// stored byte that will lie beyond the end
			push_request(ACT_DATA, base + 25, $urandom_range(255), WINDOW);
			// final byte fixes the end at base + 20
			push_request(ACT_FINAL, base + 19, $urandom_range(255), WINDOW);
			// later end marks are ignored
			push_request(ACT_MARK, base + 5, 0, WINDOW);
			push_request(ACT_FINAL, base + 30, $urandom_range(255), WINDOW);
			// byte exactly at the end is dropped
			push_request(ACT_DATA, base + 20, $urandom_range(255), WINDOW);
			// fill the gap out of order, stride 7 walks all of 0..18
			for (n = 0; n < 19; n++)
				push_request(ACT_DATA, base + (n * 7) % 19, $urandom_range(255), WINDOW);
			for (n = 0; n < 24; n++)
				push_request(ACT_DRAIN, 0, 0, $urandom_range(8191, 1));
			// closed stream: nothing stored, nothing released
			push_request(ACT_DATA, base + 20, $urandom_range(255), WINDOW);
			push_request(ACT_DATA, base + 25, $urandom_range(255), WINDOW);
			push_request(ACT_MARK, base + 40, 0, WINDOW);
			push_request(ACT_FINAL, base + 3, $urandom_range(255), 8191);
			push_request(ACT_DRAIN, 0, 0, WINDOW);
		end

		while (byte_requests.size() != 0 || item_valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		// an idle tail so a stray extra result would still be caught
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/brs_pkg.sv
hdl/brs_window.sv
hdl/byte_stream_reassembler.sv
test/byte_stream_reassembler_test.sv
